// ===== rtl/sssp_pkg.sv =====
package sssp_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_INNER_RADIUS    = 3'd0,
        REG_OUTER_RADIUS    = 3'd1,
        REG_HEMISPHERE_MODE = 3'd2,
        REG_CONE_MODE       = 3'd3,
        REG_CONE_COS_MIN    = 3'd4,
        REG_CENTER_X        = 3'd5,
        REG_CENTER_Y        = 3'd6,
        REG_CENTER_Z        = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] CONE_NONE = 2'd0;
    localparam logic [1:0] CONE_POS  = 2'd1;
    localparam logic [1:0] CONE_NEG  = 2'd2;

    localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

    typedef struct packed {
        logic [31:0]        rand_radius;
        logic [31:0]        rand_polar;
        logic signed [31:0] azimuth_cos;
        logic signed [31:0] azimuth_sin;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic [CfgIdxW-1:0]  index;
        logic [CfgDataW-1:0] data;
    } cfg_word_t;

endpackage

// ===== rtl/sssp_if.sv =====
interface sssp_in_if;
    logic                valid;
    logic                ready;
    sssp_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sssp_out_if;
    logic                valid;
    logic                ready;
    sssp_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sssp_cfg_if;
    logic                valid;
    logic                ready;
    sssp_pkg::cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/spherical_shell_point_sampler_top.sv =====
// channel | dir | payload
// in      | in  | rand_radius, rand_polar, azimuth_cos, azimuth_sin
// out     | out | point_x, point_y, point_z, saturated
// cfg     | in  | index, data (register write, always ready)
// one word per cycle sustained unless the output stalls; stages from input accept to output valid:
// 32 cube root steps, 2 for radius, cosine and its square, 31 square root steps,
// then 6 for products, center add and saturation
// a stalled output freezes the whole pipe; nothing is lost or repeated
// reset clears valid bits and sets the config registers to their reset values
module spherical_shell_point_sampler_top (
    input logic clk,
    input logic rst_n,
    sssp_in_if.sink    in_ch,
    sssp_out_if.source out_ch,
    sssp_cfg_if.sink   cfg_ch
);

    localparam int unsigned CbrtN = 32;
    localparam int unsigned MidN = 2;
    localparam int unsigned SqrtN = 31;
    localparam int unsigned TailN = 6;
    localparam int unsigned Depth = CbrtN + MidN + SqrtN + TailN;

    logic [30:0]        inner_reg, outer_reg;
    logic signed [1:0]  hemi_reg;
    logic [1:0]         cone_reg;
    logic signed [31:0] cmin_reg, cx_reg, cy_reg, cz_reg;

    logic adv;
    logic [Depth-1:0] v_reg;

    assign cfg_ch.ready = 1'b1;
    assign adv = !v_reg[Depth-1] || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = v_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= '0;
            outer_reg <= 31'd65536;
            hemi_reg  <= '0;
            cone_reg  <= sssp_pkg::CONE_NONE;
            cmin_reg  <= sssp_pkg::OneQ30;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.data.index)
                sssp_pkg::REG_INNER_RADIUS:    inner_reg <= cfg_ch.data.data[30:0];
                sssp_pkg::REG_OUTER_RADIUS:    outer_reg <= cfg_ch.data.data[30:0];
                sssp_pkg::REG_HEMISPHERE_MODE: hemi_reg  <= cfg_ch.data.data[1:0];
                sssp_pkg::REG_CONE_MODE:       cone_reg  <= cfg_ch.data.data[1:0];
                sssp_pkg::REG_CONE_COS_MIN:    cmin_reg  <= cfg_ch.data.data;
                sssp_pkg::REG_CENTER_X:        cx_reg    <= cfg_ch.data.data;
                sssp_pkg::REG_CENTER_Y:        cy_reg    <= cfg_ch.data.data;
                sssp_pkg::REG_CENTER_Z:        cz_reg    <= cfg_ch.data.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[Depth-2:0], in_ch.valid};
    end

    // cube root of rand_radius * 2^64, one result bit per stage, shift and add only
    for (genvar i = 0; i < CbrtN; i++) begin : g_cbrt
        logic [71:0]        rem_in;
        logic [31:0]        y_in;
        logic [63:0]        sq_in;
        logic [31:0]        r_in, p_in;
        logic signed [31:0] ca_in, sa_in;
        logic [95:0]        num;
        logic [71:0]        rs, tr;
        logic               ge;
        logic [71:0]        rem_reg;
        logic [31:0]        y_reg;
        logic [63:0]        sq_reg;
        logic [31:0]        r_reg, p_reg;
        logic signed [31:0] ca_reg, sa_reg;

        if (i == 0) begin : g_src
            assign rem_in = '0;
            assign y_in   = '0;
            assign sq_in  = '0;
            assign r_in   = in_ch.data.rand_radius;
            assign p_in   = in_ch.data.rand_polar;
            assign ca_in  = in_ch.data.azimuth_cos;
            assign sa_in  = in_ch.data.azimuth_sin;
        end else begin : g_src
            assign rem_in = g_cbrt[i-1].rem_reg;
            assign y_in   = g_cbrt[i-1].y_reg;
            assign sq_in  = g_cbrt[i-1].sq_reg;
            assign r_in   = g_cbrt[i-1].r_reg;
            assign p_in   = g_cbrt[i-1].p_reg;
            assign ca_in  = g_cbrt[i-1].ca_reg;
            assign sa_in  = g_cbrt[i-1].sa_reg;
        end

        // remainder gains the next three bits; trial is 12 y^2 + 6 y + 1
        assign num = {r_in, 64'd0};
        assign rs = {rem_in[68:0], num[95 - 3 * i -: 3]};
        assign tr = {5'd0, sq_in, 3'd0} + {6'd0, sq_in, 2'd0} + {38'd0, y_in, 2'd0}
                  + {39'd0, y_in, 1'b0} + 72'd1;
        assign ge = rs >= tr;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg <= ge ? rs - tr : rs;
                y_reg   <= {y_in[30:0], ge};
                sq_reg  <= ge ? {sq_in[61:0], 2'b0} + {30'd0, y_in, 2'b0} + 64'd1
                              : {sq_in[61:0], 2'b0};
                r_reg   <= r_in;
                p_reg   <= p_in;
                ca_reg  <= ca_in;
                sa_reg  <= sa_in;
            end
        end
    end

    // radius and polar cosine
    logic signed [32:0] diff;
    logic signed [65:0] dprod;
    logic signed [33:0] rad_next;
    logic signed [32:0] dcone;
    logic [32:0]        mag;
    logic [64:0]        prod;
    logic signed [33:0] cth_c;
    logic signed [31:0] cth_next;
    logic               cone_on;

    always_comb
    begin
        diff = $signed({2'b0, outer_reg}) - $signed({2'b0, inner_reg});
        dprod = 66'(diff) * $signed({34'd0, g_cbrt[CbrtN-1].y_reg});
        rad_next = $signed({3'b0, inner_reg}) + 34'(dprod >>> 32);
        cone_on = cone_reg == sssp_pkg::CONE_POS || cone_reg == sssp_pkg::CONE_NEG;
        dcone = 33'(sssp_pkg::OneQ30) - 33'(cmin_reg);
        mag = dcone[32] ? 33'(-dcone) : 33'(dcone);
        prod = 65'(mag) * 65'(g_cbrt[CbrtN-1].p_reg);
        if (dcone[32])
            cth_c = 34'(cmin_reg) - $signed(34'((prod + 65'hFFFF_FFFF) >> 32));
        else
            cth_c = 34'(cmin_reg) + $signed(34'(prod >> 32));
        if (cth_c > 34'(sssp_pkg::OneQ30))
            cth_next = sssp_pkg::OneQ30;
        else if (cth_c < -34'(sssp_pkg::OneQ30))
            cth_next = -sssp_pkg::OneQ30;
        else
            cth_next = cth_c[31:0];
        if (!cone_on)
            cth_next = $signed({1'b0, g_cbrt[CbrtN-1].p_reg[31:1]}) - sssp_pkg::OneQ30;
        if (cone_reg == sssp_pkg::CONE_NEG)
            rad_next = -rad_next;
    end

    logic signed [33:0] m1_rad_reg, m2_rad_reg;
    logic signed [31:0] m1_cth_reg, m1_ca_reg, m1_sa_reg;
    logic signed [31:0] m2_cth_reg, m2_ca_reg, m2_sa_reg;
    logic [63:0]        m2_v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_rad_reg <= rad_next;
            m1_cth_reg <= cth_next;
            m1_ca_reg  <= g_cbrt[CbrtN-1].ca_reg;
            m1_sa_reg  <= g_cbrt[CbrtN-1].sa_reg;
            m2_v_reg   <= (64'd1 << 60) - 64'(m1_cth_reg) * 64'(m1_cth_reg);
            m2_rad_reg <= m1_rad_reg;
            m2_cth_reg <= m1_cth_reg;
            m2_ca_reg  <= m1_ca_reg;
            m2_sa_reg  <= m1_sa_reg;
        end
    end

    // square root of 2^60 - cos^2, one result bit from two radicand bits per stage
    for (genvar j = 0; j < SqrtN; j++) begin : g_sqrt
        logic [63:0]        v_in, res_in;
        logic signed [33:0] rad_in;
        logic signed [31:0] cth_in, ca_in, sa_in;
        logic [63:0]        b, sum;
        logic               ge;
        logic [63:0]        v_reg, res_reg;
        logic signed [33:0] rad_reg;
        logic signed [31:0] cth_reg, ca_reg, sa_reg;

        if (j == 0) begin : g_src
            assign v_in   = m2_v_reg;
            assign res_in = '0;
            assign rad_in = m2_rad_reg;
            assign cth_in = m2_cth_reg;
            assign ca_in  = m2_ca_reg;
            assign sa_in  = m2_sa_reg;
        end else begin : g_src
            assign v_in   = g_sqrt[j-1].v_reg;
            assign res_in = g_sqrt[j-1].res_reg;
            assign rad_in = g_sqrt[j-1].rad_reg;
            assign cth_in = g_sqrt[j-1].cth_reg;
            assign ca_in  = g_sqrt[j-1].ca_reg;
            assign sa_in  = g_sqrt[j-1].sa_reg;
        end

        assign b = 64'd1 << (60 - 2 * j);
        assign sum = res_in + b;
        assign ge = v_in >= sum;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg   <= ge ? v_in - sum : v_in;
                res_reg <= ge ? (res_in >> 1) + b : res_in >> 1;
                rad_reg <= rad_in;
                cth_reg <= cth_in;
                ca_reg  <= ca_in;
                sa_reg  <= sa_in;
            end
        end
    end

    // products, hemisphere fold, center add, saturation
    logic signed [33:0] t0_rad_reg;
    logic signed [31:0] t0_cth_reg, t0_ca_reg, t0_sa_reg, t0_sth_reg;
    logic signed [63:0] t1_t_reg, t1_z_reg;
    logic signed [31:0] t1_ca_reg, t1_sa_reg;
    logic signed [33:0] t2_t_reg, t2_z_reg;
    logic signed [31:0] t2_ca_reg, t2_sa_reg;
    logic signed [65:0] t3_x_reg, t3_y_reg;
    logic signed [33:0] t3_z_reg;
    logic signed [35:0] t4_x_reg, t4_y_reg, t4_z_reg;
    sssp_pkg::out_word_t t5_reg;

    logic signed [35:0] zf;
    logic signed [31:0] sx, sy, sz;
    logic               fx, fy, fz;

    function automatic logic signed [31:0] sat(input logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    always_comb
    begin
        zf = 36'(t3_z_reg);
        if (hemi_reg > 0 && zf < 0)
            zf = -zf;
        else if (hemi_reg < 0 && zf > 0)
            zf = -zf;
        sx = sat(t4_x_reg);
        sy = sat(t4_y_reg);
        sz = sat(t4_z_reg);
        fx = t4_x_reg != 36'(sx);
        fy = t4_y_reg != 36'(sy);
        fz = t4_z_reg != 36'(sz);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_rad_reg <= g_sqrt[SqrtN-1].rad_reg;
            t0_cth_reg <= g_sqrt[SqrtN-1].cth_reg;
            t0_ca_reg  <= g_sqrt[SqrtN-1].ca_reg;
            t0_sa_reg  <= g_sqrt[SqrtN-1].sa_reg;
            t0_sth_reg <= g_sqrt[SqrtN-1].res_reg[31:0];
            t1_t_reg   <= 64'(t0_rad_reg) * 64'(t0_sth_reg);
            t1_z_reg   <= 64'(t0_rad_reg) * 64'(t0_cth_reg);
            t1_ca_reg  <= t0_ca_reg;
            t1_sa_reg  <= t0_sa_reg;
            t2_t_reg   <= 34'(t1_t_reg >>> 30);
            t2_z_reg   <= 34'(t1_z_reg >>> 30);
            t2_ca_reg  <= t1_ca_reg;
            t2_sa_reg  <= t1_sa_reg;
            t3_x_reg   <= 66'(t2_t_reg) * 66'(t2_ca_reg);
            t3_y_reg   <= 66'(t2_t_reg) * 66'(t2_sa_reg);
            t3_z_reg   <= t2_z_reg;
            t4_x_reg   <= 36'(t3_x_reg >>> 30) + 36'(cx_reg);
            t4_y_reg   <= 36'(t3_y_reg >>> 30) + 36'(cy_reg);
            t4_z_reg   <= zf + 36'(cz_reg);
            t5_reg     <= '{point_x: sx, point_y: sy, point_z: sz,
                            saturated: fx || fy || fz};
        end
    end

    assign out_ch.data = t5_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |=> $stable(v_reg))
        else $error("pipe moved while stalled");

endmodule

// ===== bench/spherical_shell_point_sampler_top_tb.sv =====
module spherical_shell_point_sampler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    class point_scoreboard;
        sssp_pkg::out_word_t pending_points[$];
        int unsigned mismatches;

        logic [30:0] inner_r;
        logic [30:0] outer_r;
        logic signed [1:0] hemi;
        logic [1:0] cone;
        logic signed [31:0] cone_cmin;
        logic signed [31:0] ctr_x;
        logic signed [31:0] ctr_y;
        logic signed [31:0] ctr_z;

        function new();
            mismatches = 0;
            inner_r = '0;
            outer_r = 31'd65536;
            hemi = '0;
            cone = sssp_pkg::CONE_NONE;
            cone_cmin = sssp_pkg::OneQ30;
            ctr_x = '0;
            ctr_y = '0;
            ctr_z = '0;
        endfunction

        function void write_reg(sssp_pkg::cfg_reg_t idx, logic [31:0] value);
            case (idx)
                sssp_pkg::REG_INNER_RADIUS:    inner_r = value[30:0];
                sssp_pkg::REG_OUTER_RADIUS:    outer_r = value[30:0];
                sssp_pkg::REG_HEMISPHERE_MODE: hemi = value[1:0];
                sssp_pkg::REG_CONE_MODE:       cone = value[1:0];
                sssp_pkg::REG_CONE_COS_MIN:    cone_cmin = value;
                sssp_pkg::REG_CENTER_X:        ctr_x = value;
                sssp_pkg::REG_CENTER_Y:        ctr_y = value;
                sssp_pkg::REG_CENTER_Z:        ctr_z = value;
                default: ;
            endcase
        endfunction

        function automatic longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function automatic logic [31:0] cube_root(logic [31:0] r);
            logic [31:0] c;
            logic [31:0] trial;
            logic [95:0] cube;
            c = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = c | (32'd1 << b);
                cube = 96'(trial) * trial * trial;
                if (cube <= {r, 64'd0})
                    c = trial;
            end
            return c;
        endfunction

        function automatic longint root_floor(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function automatic logic signed [31:0] clamp32(longint v, ref logic flag);
            if (v > 64'sd2147483647)
            begin
                flag = 1'b1;
                return 32'sh7fff_ffff;
            end
            if (v < -64'sd2147483648)
            begin
                flag = 1'b1;
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        function void note_input(sssp_pkg::in_word_t w);
            longint diff, rad, cth, sth, t, x, y, z, d, one;
            logic [95:0] prod;
            logic [31:0] mag;
            logic flag;
            sssp_pkg::out_word_t e;
            one = longint'(1) << 30;
            flag = 1'b0;
            diff = longint'(outer_r) - longint'(inner_r);
            rad = longint'(inner_r) + floor_shr(diff * longint'(cube_root(w.rand_radius)), 32);
            if (cone == sssp_pkg::CONE_POS || cone == sssp_pkg::CONE_NEG)
            begin
                d = one - longint'(cone_cmin);
                mag = d < 0 ? 32'(-d) : 32'(d);
                prod = 96'(mag) * w.rand_polar;
                if (d < 0)
                    cth = longint'(cone_cmin) - longint'((prod + 96'hffff_ffff) >> 32);
                else
                    cth = longint'(cone_cmin) + longint'(prod >> 32);
                if (cth > one)
                    cth = one;
                if (cth < -one)
                    cth = -one;
                if (cone == sssp_pkg::CONE_NEG)
                    rad = -rad;
            end
            else
                cth = longint'(w.rand_polar >> 1) - one;
            sth = root_floor((64'd1 << 60) - 64'(cth * cth));
            t = floor_shr(rad * sth, 30);
            x = floor_shr(t * longint'(w.azimuth_cos), 30);
            y = floor_shr(t * longint'(w.azimuth_sin), 30);
            z = floor_shr(rad * cth, 30);
            if (hemi > 0)
                z = z < 0 ? -z : z;
            else if (hemi < 0)
                z = z > 0 ? -z : z;
            e.point_x = clamp32(x + longint'(ctr_x), flag);
            e.point_y = clamp32(y + longint'(ctr_y), flag);
            e.point_z = clamp32(z + longint'(ctr_z), flag);
            e.saturated = flag;
            pending_points.insert(pending_points.size(), e);
        endfunction

        function void check_point(sssp_pkg::out_word_t got);
            sssp_pkg::out_word_t e;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point word %h", got);
                return;
            end
            e = pending_points.pop_front();
            if (got.point_x !== e.point_x || got.point_y !== e.point_y
                || got.point_z !== e.point_z || got.saturated !== e.saturated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"point mismatch: exp x=%0d y=%0d z=%0d s=%0b",
                              " got x=%0d y=%0d z=%0d s=%0b"},
                        e.point_x, e.point_y, e.point_z, e.saturated,
                        got.point_x, got.point_y, got.point_z, got.saturated);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    sssp_in_if  in_ch ();
    sssp_out_if out_ch ();
    sssp_cfg_if cfg_ch ();
    point_scoreboard sb;
    bit stall_enable;

    spherical_shell_point_sampler_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        sb = new();
        stall_enable = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
    end

    // receiver stall pattern and output check
    always @(posedge clk)
    begin
        int phase;
        if (out_ch.valid && out_ch.ready)
            sb.check_point(out_ch.data);
        phase = $urandom_range(0, 99);
        if (!stall_enable)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= (phase < 70) || ($time / 2000) % 3 == 0;
    end

    task automatic write_cfg(sssp_pkg::cfg_reg_t idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, data: value};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(sssp_pkg::in_word_t w);
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_input(w);
    endtask

    task automatic send_gap(int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_unit();
        case ($urandom_range(0, 5))
            0: return 32'h4000_0000;
            1: return 32'hc000_0000;
            2: return 32'h0;
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    function automatic sssp_pkg::in_word_t rand_word();
        sssp_pkg::in_word_t w;
        w.rand_radius = $urandom();
        w.rand_polar = $urandom();
        w.azimuth_cos = rand_unit();
        w.azimuth_sin = rand_unit();
        if ($urandom_range(0, 9) == 0)
            w.azimuth_cos = $urandom();
        if ($urandom_range(0, 9) == 0)
            w.azimuth_sin = $urandom();
        if ($urandom_range(0, 15) == 0)
            w.rand_radius = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        return w;
    endfunction

    task automatic random_burst(int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len && sent < count; i++)
            begin
                send_word(rand_word());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                send_gap($urandom_range(0, 6));
        end
    endtask

    task automatic set_all(logic [31:0] inner, logic [31:0] outer, logic [1:0] hemi,
                           logic [1:0] cone, logic [31:0] cmin, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] cz);
        write_cfg(sssp_pkg::REG_INNER_RADIUS, inner);
        write_cfg(sssp_pkg::REG_OUTER_RADIUS, outer);
        write_cfg(sssp_pkg::REG_HEMISPHERE_MODE, hemi);
        write_cfg(sssp_pkg::REG_CONE_MODE, cone);
        write_cfg(sssp_pkg::REG_CONE_COS_MIN, cmin);
        write_cfg(sssp_pkg::REG_CENTER_X, cx);
        write_cfg(sssp_pkg::REG_CENTER_Y, cy);
        write_cfg(sssp_pkg::REG_CENTER_Z, cz);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes under reset settings
        send_word('{32'h0, 32'h0, 32'h4000_0000, 32'h0});
        send_word('{32'hffff_ffff, 32'hffff_ffff, 32'hc000_0000, 32'h4000_0000});
        send_word('{32'h8000_0000, 32'h8000_0000, 32'h0, 32'hc000_0000});
        send_word('{32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h7fff_ffff});
        send_word('{32'h1234_5678, 32'hfedc_ba98, 32'h8000_0000, 32'h8000_0000});
        wait_drained();

        // outer below inner, cone bound out of range, cone mode three
        set_all(32'h7fff_ffff, 32'h0, 2'b10, 2'd3, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        send_word('{32'hffff_ffff, 32'h4000_0000, 32'h4000_0000, 32'h0});
        send_word('{32'h0, 32'hffff_ffff, 32'h0, 32'h4000_0000});
        wait_drained();
        write_cfg(sssp_pkg::REG_CONE_MODE, sssp_pkg::CONE_POS);
        send_word('{32'hffff_ffff, 32'hffff_ffff, 32'h4000_0000, 32'h0});
        send_word('{32'h8000_0000, 32'h0, 32'h2d41_3ccd, 32'h2d41_3ccd});
        wait_drained();
        write_cfg(sssp_pkg::REG_CONE_COS_MIN, 32'h7fff_ffff);
        write_cfg(sssp_pkg::REG_CONE_MODE, sssp_pkg::CONE_NEG);
        write_cfg(sssp_pkg::REG_HEMISPHERE_MODE, 2'b01);
        send_word('{32'hffff_ffff, 32'h8000_0000, 32'hc000_0000, 32'h4000_0000});
        send_word('{32'h0, 32'hffff_ffff, 32'h4000_0000, 32'h4000_0000});
        wait_drained();
        // saturation through center offsets
        set_all(32'h0, 32'h7fff_ffff, 2'b11, sssp_pkg::CONE_NONE, 32'hc000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_0000);
        send_word('{32'hffff_ffff, 32'hffff_ffff, 32'h4000_0000, 32'hc000_0000});
        send_word('{32'hffff_ffff, 32'h0, 32'hc000_0000, 32'h4000_0000});
        send_word('{32'hffff_ffff, 32'h8000_0000, 32'h4000_0000, 32'h4000_0000});
        wait_drained();

        stall_enable = 1'b1;
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [31:0] a;
            logic [31:0] b;
            a = $urandom_range(0, 32'h0010_0000);
            b = a + $urandom_range(0, 32'h0100_0000);
            if (ph == 3)
                b = 32'h7fff_ffff;
            if (ph == 5)
                b = a >> 1;
            set_all(a, b, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    ph == 6 ? 32'hc000_0000 : rand_unit(),
                    ph == 3 ? 32'h7000_0000 : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                    ph == 7 ? 32'h8000_0000 : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                    $urandom());
            stall_enable = (ph % 3) != 2;
            random_burst(150);
            wait_drained();
        end

        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
